FILE: design/bsp_pkg.sv
// Shared types, codes and constants for the bencode stream parser.
package bsp_pkg;

  localparam int NEST_DEPTH = 32;
  localparam int PTR_W      = $clog2(NEST_DEPTH + 1);
  localparam int IDX_W      = $clog2(NEST_DEPTH);

  localparam int STR_LEN_W  = 17;
  localparam logic [STR_LEN_W-1:0] STR_LEN_SAT = 17'd65536;

  localparam logic [62:0] MAG_MAX = {63{1'b1}};

  // Stack entry codes
  localparam logic [1:0] ENT_NONE = 2'd0;
  localparam logic [1:0] ENT_LIST = 2'd1;
  localparam logic [1:0] ENT_DICT = 2'd2;
  localparam logic [1:0] ENT_KEY  = 2'd3;

  // Token kinds
  localparam logic [2:0] KIND_INT      = 3'd0;
  localparam logic [2:0] KIND_STR_HDR  = 3'd1;
  localparam logic [2:0] KIND_STR_BYTE = 3'd2;
  localparam logic [2:0] KIND_LIST     = 3'd3;
  localparam logic [2:0] KIND_DICT     = 3'd4;
  localparam logic [2:0] KIND_CLOSE    = 3'd5;
  localparam logic [2:0] KIND_ACCEPT   = 3'd6;
  localparam logic [2:0] KIND_ERROR    = 3'd7;

  // Error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_BAD_CHAR   = 4'd1;
  localparam logic [3:0] ERR_INT_OVF    = 4'd2;
  localparam logic [3:0] ERR_STR_LONG   = 4'd3;
  localparam logic [3:0] ERR_TOO_DEEP   = 4'd4;
  localparam logic [3:0] ERR_STRAY_END  = 4'd5;
  localparam logic [3:0] ERR_TRAILING   = 4'd6;
  localparam logic [3:0] ERR_UNCLOSED   = 4'd7;
  localparam logic [3:0] ERR_KEY_TYPE   = 4'd8;
  localparam logic [3:0] ERR_NO_VALUE   = 4'd9;

  // Characters
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Config register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_MAX_STR_LEN = 1'b0;
  localparam logic [15:0] MAX_STR_LEN_RST = 16'd256;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic        key;
    logic [5:0]  level;
    logic [3:0]  code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } core_out_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [63:0] value, logic key,
                                  logic [PTR_W-1:0] level, logic [3:0] code,
                                  logic last);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.key   = key;
    r.level = 6'(level);
    r.code  = code;
    r.last  = last;
    return r;
  endfunction

endpackage

FILE: design/bsp_core.sv
// Bencode lexer and nesting checker: one byte in, up to two results out per cycle in which in_fire is high.
module bsp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic [15:0]         max_str_len,
  output bsp_pkg::core_out_t  res
);
  import bsp_pkg::*;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_INT_SIGN = 6'b000010,
    MODE_INT_BODY = 6'b000100,
    MODE_STR_LEN  = 6'b001000,
    MODE_STR_DATA = 6'b010000,
    MODE_SKIP     = 6'b100000
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [62:0]          acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic                 hasd_r, hasd_nxt;
  logic [STR_LEN_W-1:0] srem_r, srem_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic                 root_r, root_nxt;
  logic [3:0]           serr_r, serr_nxt;
  logic [1:0]           stack_r [NEST_DEPTH];

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [1:0]           wr_val;

  logic [1:0]           top;
  logic [IDX_W-1:0]     top_idx;

  assign top_idx = IDX_W'(ptr_r - PTR_W'(1));
  assign top     = (ptr_r == '0) ? ENT_NONE : stack_r[top_idx];

  always_comb begin
    logic             is_digit;
    logic [3:0]       d;
    logic [3:0]       err;
    logic             tok_vld;
    res_t             tok;
    logic             end_vld;
    res_t             end_res;
    logic [66:0]      sum;
    logic [20:0]      lsum;
    logic             ok;
    logic [STR_LEN_W-1:0] rem_dec;
    logic             str_done;

    is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    d        = 4'(in_byte - CH_ZERO);
    err      = ERR_NONE;
    tok_vld  = 1'b0;
    tok      = '0;
    end_vld  = 1'b0;
    end_res  = '0;
    sum      = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + 67'(d);
    lsum     = {1'b0, srem_r, 3'b000} + {3'b000, srem_r, 1'b0} + 21'(d);
    ok       = 1'b0;
    rem_dec  = (srem_r != '0) ? srem_r - STR_LEN_W'(1) : srem_r;
    str_done = 1'b0;

    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    hasd_nxt = hasd_r;
    srem_nxt = srem_r;
    ptr_nxt  = ptr_r;
    root_nxt = root_r;
    serr_nxt = serr_r;
    wr_en    = 1'b0;
    wr_idx   = IDX_W'(ptr_r);
    wr_val   = ENT_NONE;

    case (mode_r)
      MODE_SKIP: begin
        if (in_last) begin
          end_vld = 1'b1;
          end_res = mk_res(KIND_ERROR, '0, 1'b0, ptr_r, serr_r, 1'b1);
        end
      end
      MODE_IDLE: begin
        if (in_byte == CH_I || in_byte == CH_L || in_byte == CH_D || is_digit) begin
          if (ptr_r == '0) begin
            err = root_r ? ERR_TRAILING : ERR_NONE;
          end else if (!is_digit && top == ENT_DICT) begin
            err = ERR_KEY_TYPE;
          end
        end
        if (in_byte == CH_I) begin
          if (err == ERR_NONE) begin
            mode_nxt = MODE_INT_SIGN;
            acc_nxt  = '0;
            neg_nxt  = 1'b0;
            hasd_nxt = 1'b0;
          end
        end else if (is_digit) begin
          if (err == ERR_NONE) begin
            mode_nxt = MODE_STR_LEN;
            srem_nxt = STR_LEN_W'(d);
          end
        end else if (in_byte == CH_L || in_byte == CH_D) begin
          if (err == ERR_NONE) begin
            wr_val = (in_byte == CH_L) ? ENT_LIST : ENT_DICT;
            if (top == ENT_KEY) begin
              // pending key slot is replaced by the container
              wr_en  = 1'b1;
              wr_idx = top_idx;
            end else if (ptr_r >= PTR_W'(NEST_DEPTH)) begin
              err = ERR_TOO_DEEP;
            end else begin
              wr_en   = 1'b1;
              ptr_nxt = ptr_r + PTR_W'(1);
            end
            if (err == ERR_NONE) begin
              tok_vld = 1'b1;
              tok = mk_res((in_byte == CH_L) ? KIND_LIST : KIND_DICT, '0, 1'b0,
                           ptr_nxt, ERR_NONE, 1'b0);
            end
          end
        end else if (in_byte == CH_E) begin
          if (ptr_r == '0) begin
            err = ERR_STRAY_END;
          end else if (top == ENT_KEY) begin
            err = ERR_NO_VALUE;
          end else begin
            ptr_nxt = ptr_r - PTR_W'(1);
            if (ptr_nxt == '0) root_nxt = 1'b1;
            tok_vld = 1'b1;
            tok = mk_res(KIND_CLOSE, '0, 1'b0, ptr_nxt, ERR_NONE, 1'b0);
          end
        end else begin
          err = ERR_BAD_CHAR;
        end
      end
      MODE_INT_SIGN, MODE_INT_BODY: begin
        if (is_digit) begin
          if (sum > {4'b0000, MAG_MAX}) begin
            err = ERR_INT_OVF;
          end else begin
            acc_nxt  = sum[62:0];
            hasd_nxt = 1'b1;
            mode_nxt = MODE_INT_BODY;
          end
        end else if (mode_r == MODE_INT_SIGN && in_byte == CH_MINUS) begin
          neg_nxt  = 1'b1;
          mode_nxt = MODE_INT_BODY;
        end else if (mode_r == MODE_INT_BODY && in_byte == CH_E && hasd_r) begin
          mode_nxt = MODE_IDLE;
          if (top == ENT_KEY) ptr_nxt = ptr_r - PTR_W'(1);
          if (ptr_nxt == '0) root_nxt = 1'b1;
          tok_vld = 1'b1;
          tok = mk_res(KIND_INT, neg_r ? (64'd0 - {1'b0, acc_r}) : {1'b0, acc_r},
                       1'b0, ptr_nxt, ERR_NONE, 1'b0);
        end else begin
          err = ERR_BAD_CHAR;
        end
      end
      MODE_STR_LEN: begin
        if (is_digit) begin
          srem_nxt = (lsum > 21'(STR_LEN_SAT)) ? STR_LEN_SAT : STR_LEN_W'(lsum);
        end else if (in_byte == CH_COLON) begin
          if (srem_r > {1'b0, max_str_len}) begin
            err = ERR_STR_LONG;
          end else begin
            tok_vld = 1'b1;
            tok = mk_res(KIND_STR_HDR, 64'(srem_r), top == ENT_DICT, ptr_r,
                         ERR_NONE, 1'b0);
            if (srem_r == '0) str_done = 1'b1;
            else mode_nxt = MODE_STR_DATA;
          end
        end else begin
          err = ERR_BAD_CHAR;
        end
      end
      MODE_STR_DATA: begin
        tok_vld = 1'b1;
        tok = mk_res(KIND_STR_BYTE, 64'(in_byte), top == ENT_DICT, ptr_r,
                     ERR_NONE, 1'b0);
        srem_nxt = rem_dec;
        if (rem_dec == '0) str_done = 1'b1;
      end
      default: begin
        err = ERR_BAD_CHAR;
      end
    endcase

    if (str_done) begin
      mode_nxt = MODE_IDLE;
      if (top == ENT_DICT) begin
        if (ptr_r >= PTR_W'(NEST_DEPTH)) begin
          err = ERR_TOO_DEEP;
        end else begin
          wr_en   = 1'b1;
          wr_val  = ENT_KEY;
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end else begin
        if (top == ENT_KEY) ptr_nxt = ptr_r - PTR_W'(1);
        if (ptr_nxt == '0) root_nxt = 1'b1;
      end
    end

    if (mode_r != MODE_SKIP) begin
      if (err != ERR_NONE) begin
        end_vld = 1'b1;
        end_res = mk_res(KIND_ERROR, '0, 1'b0, ptr_nxt, err, in_last);
        if (!in_last) begin
          mode_nxt = MODE_SKIP;
          serr_nxt = err;
        end
      end else if (in_last) begin
        ok = (mode_nxt == MODE_IDLE) && (ptr_nxt == '0) && root_nxt;
        end_vld = 1'b1;
        end_res = mk_res(ok ? KIND_ACCEPT : KIND_ERROR, '0, 1'b0, ptr_nxt,
                         ok ? ERR_NONE : ERR_UNCLOSED, 1'b1);
      end
    end

    if (in_last) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      hasd_nxt = 1'b0;
      srem_nxt = '0;
      ptr_nxt  = '0;
      root_nxt = 1'b0;
      serr_nxt = ERR_NONE;
    end

    res.cnt = {1'b0, tok_vld} + {1'b0, end_vld};
    res.r0  = tok_vld ? tok : end_res;
    res.r1  = end_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      neg_r  <= 1'b0;
      hasd_r <= 1'b0;
      srem_r <= '0;
      ptr_r  <= '0;
      root_r <= 1'b0;
      serr_r <= ERR_NONE;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      hasd_r <= hasd_nxt;
      srem_r <= srem_nxt;
      ptr_r  <= ptr_nxt;
      root_r <= root_nxt;
      serr_r <= serr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      stack_r[wr_idx] <= wr_val;
    end
  end

endmodule

FILE: design/bencode_stream_parser_top.sv
// Top level of the bencode stream parser: config register, parser core, result queue.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata[7:0] byte_in, tlast last_byte
//  out_    | out | out_tvalid/tready  | tdata value/level/code, tuser kind/key, tlast
//  cfg_    | in  | APB psel/penable   | reg 0 max_string_length at 0x0
//
// One byte is taken per cycle while in_tready is high; each request is parsed in the cycle it is accepted.
// A byte yields zero, one or two results into a 4-entry result queue, drained one per cycle while out_tready is high.
// in_tready drops while the queue holds more than two results.
// rst_n is synchronous; the nesting stack contents need no reset.
module bencode_stream_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] byte_in
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [79:0]                     out_tdata,  // [63:0] token_value, [69:64] nest_level, [73:70] error_code
  output logic [3:0]                      out_tuser,  // [2:0] token_kind, [3] is_dict_key
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bsp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import bsp_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  logic [15:0]        max_len_r;
  logic               in_fire;
  logic               out_fire;
  core_out_t          core_res;

  res_t               q_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  res_t               head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_STR_LEN) ? {16'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_STR_LEN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_MAX_STR_LEN) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  assign in_tready = (cnt_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  bsp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .max_str_len (max_len_r),
    .res         (core_res)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) cnt_nxt = cnt_nxt + Q_CNT_W'(core_res.cnt);
    if (out_fire) cnt_nxt = cnt_nxt - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= wr_ptr_r + Q_IDX_W'(core_res.cnt);
      if (out_fire) rd_ptr_r <= rd_ptr_r + Q_IDX_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && core_res.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= core_res.r0;
    end
    if (in_fire && core_res.cnt == 2'd2) begin
      q_r[wr_ptr_r + Q_IDX_W'(1)] <= core_res.r1;
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {6'd0, head.code, head.level, head.value};
  assign out_tuser  = {head.key, head.kind};
  assign out_tlast  = head.last;

endmodule
